[rtl/core/cgrc_pkg.sv]
package cgrc_pkg;

  // field and register widths
  localparam int KIND_W     = 3;
  localparam int POS_W      = 15;
  localparam int POS_FRAC_W = 4;
  localparam int OCT_W      = 2;
  localparam int OCTC_W     = 3;
  localparam int SIZE_W     = 8;
  localparam int GRID_W     = 7;
  localparam int THR_W      = 16;
  localparam int OUT_CNT_W  = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CELL_W     = 2;
  localparam int POS_INT_MAX = (1 << (POS_W - POS_FRAC_W)) - 1;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MARK_OLD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MARK_NEW = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EVAL     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY    = 3'd4;

  // cell codes
  localparam logic [CELL_W-1:0] CELL_EMPTY = 2'd0;
  localparam logic [CELL_W-1:0] CELL_OLD   = 2'd1;
  localparam logic [CELL_W-1:0] CELL_NEW   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_THR = 2'd3;

  // register reset values
  localparam logic [SIZE_W-1:0] RST_CELL_SIZE = 8'd10;
  localparam logic [GRID_W-1:0] RST_GRID_COLS = 7'd64;
  localparam logic [GRID_W-1:0] RST_GRID_ROWS = 7'd48;
  localparam logic [THR_W-1:0]  RST_RATIO_THR = 16'd256;

endpackage

[rtl/core/cgrc_item_if.sv]
interface cgrc_item_if;
  logic                        valid;
  logic                        ready;
  logic [cgrc_pkg::KIND_W-1:0] kind;
  logic [cgrc_pkg::POS_W-1:0]  pos_x;
  logic [cgrc_pkg::POS_W-1:0]  pos_y;
  logic [cgrc_pkg::OCT_W-1:0]  octave;

  modport source (output valid, kind, pos_x, pos_y, octave, input ready);
  modport sink (input valid, kind, pos_x, pos_y, octave, output ready);
endinterface

[rtl/core/cgrc_result_if.sv]
interface cgrc_result_if;
  logic                           valid;
  logic                           ready;
  logic                           add_frame;
  logic [cgrc_pkg::OUT_CNT_W-1:0] old_cells;
  logic [cgrc_pkg::OUT_CNT_W-1:0] new_cells;
  logic                           cell_is_old;

  modport source (output valid, add_frame, old_cells, new_cells, cell_is_old, input ready);
  modport sink (input valid, add_frame, old_cells, new_cells, cell_is_old, output ready);
endinterface

[rtl/core/cgrc_div.sv]
module cgrc_div #(
  parameter int NUM_W = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [NUM_W-1:0]            num,
  input  logic [cgrc_pkg::SIZE_W-1:0] den,
  output logic                        busy,
  output logic                        done,
  output logic [NUM_W-1:0]            quo
);
  import cgrc_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [SIZE_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic [SIZE_W:0]   trial;

  // restoring divide, one quotient bit per cycle; quo shifts out the dividend
  assign trial = {rem, quo[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        quo  <= num;
        rem  <= '0;
        cnt  <= CNT_W'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= SIZE_W'(trial - {1'b0, den});
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= SIZE_W'(trial);
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[rtl/core/cgrc_ram.sv]
module cgrc_ram #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [cgrc_pkg::CELL_W-1:0] wdata,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [cgrc_pkg::CELL_W-1:0] rdata
);
  import cgrc_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/coverage_grid_ratio_check.sv]
// Operations: clear sweeps MAX_ROWS*MAX_COLS cells; mark divides four box edges on the
// DIV_W-bit divider (12 bits by default) and walks the box, mark new reading first;
// evaluate scans the grid in use; query divides two indexes, reads a cell if on grid.
// Throughput: one item at a time; the bit-serial divider and the cell-by-cell walk set it.
// Reset: synchronous, active high; afterwards a clearing sweep over all MAX_ROWS*MAX_COLS
// cells empties the grid while no item is taken (configuration writes are taken).
module coverage_grid_ratio_check #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_ROWS   = 64,
  parameter int BOX_HALF   = 8,
  parameter int MAX_OCTAVE = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [cgrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cgrc_pkg::CFG_DATA_W-1:0] cfg_data,
  cgrc_item_if.sink                       item,
  cgrc_result_if.source                   result
);
  import cgrc_pkg::*;

  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int HALF_MAX = BOX_HALF << MAX_OCTAVE;
  // box edges in whole pixels: pos plus half-size
  localparam int DIV_W    = $clog2(POS_INT_MAX + HALF_MAX + 1);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int PROD_W   = THR_W + CNT_W;
  localparam int PINT_W   = POS_W - POS_FRAC_W;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_DIV_GO, S_DIV_WAIT, S_BOX, S_WALK_RD, S_WALK_WR,
    S_EVAL, S_EVAL_TAIL, S_EVAL_MUL, S_QRY_CHK, S_QRY_RD, S_QRY_WAIT, S_PUT
  } state_t;

  state_t state;

  // configuration registers
  logic [SIZE_W-1:0] cell_size;
  logic [GRID_W-1:0] grid_cols;
  logic [GRID_W-1:0] grid_rows;
  logic [THR_W-1:0]  ratio_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size       <= RST_CELL_SIZE;
      grid_cols       <= RST_GRID_COLS;
      grid_rows       <= RST_GRID_ROWS;
      ratio_threshold <= RST_RATIO_THR;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CELL_SIZE: cell_size       <= cfg_data[SIZE_W-1:0];
        REG_GRID_COLS: grid_cols       <= cfg_data[GRID_W-1:0];
        REG_GRID_ROWS: grid_rows       <= cfg_data[GRID_W-1:0];
        REG_RATIO_THR: ratio_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // grid in use, saturated to the built size; zero cell size acts as one
  logic [DIV_W-1:0]  cols_lim;
  logic [DIV_W-1:0]  rows_lim;
  logic [SIZE_W-1:0] den;

  assign cols_lim = (DIV_W'(grid_cols) > DIV_W'(MAX_COLS)) ? DIV_W'(MAX_COLS)
                                                             : DIV_W'(grid_cols);
  assign rows_lim = (DIV_W'(grid_rows) > DIV_W'(MAX_ROWS)) ? DIV_W'(MAX_ROWS)
                                                             : DIV_W'(grid_rows);
  assign den      = (cell_size == '0) ? SIZE_W'(1) : cell_size;

  // latched item
  logic [KIND_W-1:0] op;
  logic [PINT_W-1:0] px;
  logic [PINT_W-1:0] py;
  logic [DIV_W-1:0]  half;
  logic [OCTC_W-1:0] oct_eff;

  // Q11.4 divided by cell_size*16 equals integer pixels divided by cell_size
  assign oct_eff = ({1'b0, item.octave} > OCTC_W'(MAX_OCTAVE)) ? OCTC_W'(MAX_OCTAVE)
                                                                 : {1'b0, item.octave};

  // shared divider: four box edges for a mark, two cell indexes for a query
  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [DIV_W-1:0] div_num;
  logic [DIV_W-1:0] div_quo;
  logic [1:0]       step;
  logic [1:0]       last_step;
  logic [DIV_W-1:0] q [4];
  logic             axis_y;
  logic [DIV_W-1:0] pnum;

  assign div_start = (state == S_DIV_GO);
  assign last_step = (op == KIND_QUERY) ? 2'd1 : 2'd3;
  assign axis_y    = (op == KIND_QUERY) ? step[0] : step[1];
  assign pnum      = axis_y ? DIV_W'(py) : DIV_W'(px);

  always_comb begin
    if (op == KIND_QUERY) begin
      div_num = pnum;
    end else if (step[0]) begin
      div_num = pnum + half;
    end else begin
      // low edge left of the image clamps to column or row zero
      div_num = (pnum >= half) ? pnum - half : '0;
    end
  end

  cgrc_div #(
    .NUM_W (DIV_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // clamped box far edges
  logic [DIV_W-1:0] x_hi_c;
  logic [DIV_W-1:0] y_hi_c;
  logic             box_empty;

  assign x_hi_c    = (q[1] > cols_lim - DIV_W'(1)) ? cols_lim - DIV_W'(1) : q[1];
  assign y_hi_c    = (q[3] > rows_lim - DIV_W'(1)) ? rows_lim - DIV_W'(1) : q[3];
  assign box_empty = (cols_lim == '0) || (rows_lim == '0) || (q[0] > x_hi_c) ||
                     (q[2] > y_hi_c);

  // cell walk counters, shared by marks, evaluate scan and query
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  x_lo;
  logic [COL_W-1:0]  x_hi;
  logic [ROW_W-1:0]  y_hi;
  logic [ADDR_W-1:0] cell_addr;
  logic [ADDR_W-1:0] clr_addr;

  assign cell_addr = ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);

  // cell memory
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] mem_rdata;
  logic              sweep;

  assign sweep     = (state == S_INIT) || (state == S_CLEAR);
  assign mem_we    = sweep || ((state == S_WALK_RD) && (op == KIND_MARK_OLD)) ||
                     ((state == S_WALK_WR) && (mem_rdata == CELL_EMPTY));
  assign mem_waddr = sweep ? clr_addr : cell_addr;
  assign mem_wdata = sweep ? CELL_EMPTY : ((op == KIND_MARK_OLD) ? CELL_OLD : CELL_NEW);

  cgrc_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cell_addr),
    .rdata (mem_rdata)
  );

  // evaluate counters and ratio product
  logic [CNT_W-1:0]  old_n;
  logic [CNT_W-1:0]  new_n;
  logic              cnt_v;
  logic [PROD_W-1:0] prod;
  logic              hit;

  // output register
  logic                 out_valid;
  logic                 out_add;
  logic [OUT_CNT_W-1:0] out_old;
  logic [OUT_CNT_W-1:0] out_new;
  logic                 out_hit;

  assign item.ready         = (state == S_IDLE);
  assign result.valid       = out_valid;
  assign result.add_frame   = out_add;
  assign result.old_cells   = out_old;
  assign result.new_cells   = out_new;
  assign result.cell_is_old = out_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      cnt_v     <= 1'b0;
      old_n     <= '0;
      new_n     <= '0;
      step      <= '0;
    end else begin
      cnt_v <= (state == S_EVAL);
      // S_PUT reloads the output register itself
      if (out_valid && result.ready && (state != S_PUT)) begin
        out_valid <= 1'b0;
      end
      // scan data arrives in the cycle after its address
      if (cnt_v) begin
        if (mem_rdata == CELL_OLD) begin
          old_n <= old_n + CNT_W'(1);
        end else if (mem_rdata == CELL_NEW) begin
          new_n <= new_n + CNT_W'(1);
        end
      end

      case (state)
        S_INIT, S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (item.valid) begin
            op   <= item.kind;
            px   <= item.pos_x[POS_W-1:POS_FRAC_W];
            py   <= item.pos_y[POS_W-1:POS_FRAC_W];
            half <= DIV_W'(BOX_HALF) << oct_eff;
            step <= '0;
            row  <= '0;
            col  <= '0;
            case (item.kind)
              KIND_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              KIND_MARK_OLD, KIND_MARK_NEW, KIND_QUERY: begin
                state <= S_DIV_GO;
              end
              KIND_EVAL: begin
                old_n <= '0;
                new_n <= '0;
                state <= ((cols_lim == '0) || (rows_lim == '0)) ? S_EVAL_MUL : S_EVAL;
              end
              default: ;
            endcase
          end
        end

        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end

        S_DIV_WAIT: begin
          if (div_done) begin
            q[step] <= div_quo;
            if (step == last_step) begin
              state <= (op == KIND_QUERY) ? S_QRY_CHK : S_BOX;
            end else begin
              step  <= step + 2'd1;
              state <= S_DIV_GO;
            end
          end
        end

        S_BOX: begin
          if (box_empty) begin
            state <= S_IDLE;
          end else begin
            x_lo  <= COL_W'(q[0]);
            x_hi  <= COL_W'(x_hi_c);
            y_hi  <= ROW_W'(y_hi_c);
            col   <= COL_W'(q[0]);
            row   <= ROW_W'(q[2]);
            state <= S_WALK_RD;
          end
        end

        // mark old writes blind; mark new reads first and writes only empty cells
        S_WALK_RD, S_WALK_WR: begin
          if ((state == S_WALK_RD) && (op == KIND_MARK_NEW)) begin
            state <= S_WALK_WR;
          end else if (col == x_hi) begin
            col <= x_lo;
            if (row == y_hi) begin
              state <= S_IDLE;
            end else begin
              row   <= row + ROW_W'(1);
              state <= S_WALK_RD;
            end
          end else begin
            col   <= col + COL_W'(1);
            state <= S_WALK_RD;
          end
        end

        S_EVAL: begin
          if (DIV_W'(col) == cols_lim - DIV_W'(1)) begin
            col <= '0;
            if (DIV_W'(row) == rows_lim - DIV_W'(1)) begin
              state <= S_EVAL_TAIL;
            end else begin
              row <= row + ROW_W'(1);
            end
          end else begin
            col <= col + COL_W'(1);
          end
        end

        S_EVAL_TAIL: begin
          state <= S_EVAL_MUL;
        end

        S_EVAL_MUL: begin
          prod  <= PROD_W'(ratio_threshold) *
                   PROD_W'((old_n == '0) ? CNT_W'(1) : old_n);
          state <= S_PUT;
        end

        S_QRY_CHK: begin
          if ((q[0] < cols_lim) && (q[1] < rows_lim)) begin
            col   <= COL_W'(q[0]);
            row   <= ROW_W'(q[1]);
            state <= S_QRY_RD;
          end else begin
            hit   <= 1'b0;
            state <= S_PUT;
          end
        end

        S_QRY_RD: begin
          state <= S_QRY_WAIT;
        end

        S_QRY_WAIT: begin
          hit   <= (mem_rdata == CELL_OLD);
          state <= S_PUT;
        end

        // wait for the output register to free up, then hand the result over
        S_PUT: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            if (op == KIND_EVAL) begin
              out_add <= (PROD_W'({new_n, 8'h00}) > prod);
              out_old <= OUT_CNT_W'(old_n);
              out_new <= OUT_CNT_W'(new_n);
              out_hit <= 1'b0;
            end else begin
              out_add <= 1'b0;
              out_old <= '0;
              out_new <= '0;
              out_hit <= hit;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // divider is never restarted mid-operation
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // the evaluate scan only reads the grid
  a_eval_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL || state == S_EVAL_TAIL) |-> !mem_we)
    else $error("cell write during evaluate scan");

  // counted cells never exceed the grid
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT && op == KIND_EVAL) |->
      (({1'b0, old_n} + {1'b0, new_n}) <= (CNT_W + 1)'(DEPTH)))
    else $error("cell counts exceed grid size");

  // the read-then-write walk is for mark new only
  a_walk_wr_kind: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_WR) |-> (op == KIND_MARK_NEW) && $past(state == S_WALK_RD))
    else $error("read-modify-write walk outside mark new");

endmodule
